@@ design/kvi_pkg.sv @@
// ----------------------------------------------------------------------------
// kvi_pkg
// Shared types and constants of the keyframe vector interpolator.
// ----------------------------------------------------------------------------
package kvi_pkg;

	localparam int MAX_KEYS = 64;
	localparam int KEY_AW   = $clog2(MAX_KEYS);
	localparam int KEY_CW   = $clog2(MAX_KEYS + 1);

	// Q1.16 weight: 16 fraction bits, one integer bit for exactly 1.0
	localparam int WFRAC    = 16;
	localparam int WW       = WFRAC + 1;
	localparam int DIV_CW   = $clog2(WFRAC);
	localparam int PW       = 33 + WW + 1;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_QUERY  = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] t;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} key_t;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FIRST = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_MUL   = 7'b0010000,
		S_ADD   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

endpackage

@@ design/keyframe_vector_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// keyframe_vector_interpolator_core
// Keyframe table with linear xyz interpolation in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one request transaction:
//   append a key (req_type 0), query at time_point (1), clear the table (2).
//   Output channel (out_valid / out_stall) returns exactly one result
//   transaction per request: out_x/out_y/out_z and status.
//   in_stall is high while a request is being worked on; one request is in
//   flight at a time.
// Sequence:
//   Append, clear and unused codes go straight to the output register.
//   Query: check the first key, then scan key pairs (one table entry read
//   per cycle), run a restoring divide for the weight (skipped when the
//   span is zero or the query hits the upper key), then three multiply/add
//   passes on one shared multiplier, then load the output register.
// Reset: clears the key count, the sequencer and the output valid. Table
//   contents are not cleared; only entries below the key count are read.
// Receiver stall: the result waits in the output register; a new request is
//   still accepted and worked on, and its result is held until the output
//   register frees up.
// ----------------------------------------------------------------------------
module keyframe_vector_interpolator_core
	import kvi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] time_point,
	input  logic signed [31:0] key_x,
	input  logic signed [31:0] key_y,
	input  logic signed [31:0] key_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [1:0]         status
);

	// control state
	state_t              state_q;
	logic [KEY_CW-1:0]   key_count_q;
	logic [KEY_AW-1:0]   idx_q;
	logic [DIV_CW-1:0]   div_cnt_q;
	logic [1:0]          comp_q;
	logic                out_valid_q;

	// working registers
	key_t                key_mem_q [MAX_KEYS];
	key_t                rd_q;
	key_t                a_q;
	key_t                b_q;
	logic signed [31:0]  q_q;
	logic [31:0]         rem_q;
	logic [31:0]         span_q;
	logic [WW-1:0]       w_q;
	logic signed [PW-1:0] prod_q;
	logic [31:0]         res_x_q, res_y_q, res_z_q;
	status_t             res_st_q;
	logic [31:0]         out_x_q, out_y_q, out_z_q;
	status_t             out_st_q;

	// combinational
	logic                accept;
	logic                out_load;
	logic [KEY_AW-1:0]   rd_addr;
	logic                first_hit;
	logic                bracket;
	logic                last_key;
	logic signed [32:0]  diff_c;
	logic signed [32:0]  span_c;
	logic [32:0]         shl_c;
	logic                sub_ok;
	logic [31:0]         a_comp, b_comp;
	logic signed [32:0]  delta_c;
	logic signed [WW:0]  wt_c;
	logic signed [PW-1:0] prod_c;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// first key answers directly: single key, or query at/before its time
	assign first_hit = (key_count_q == KEY_CW'(1)) || (q_q <= $signed(rd_q.t));

	// rd_q is the entry at idx_q, a_q the one before it
	assign bracket  = ($signed(a_q.t) <= q_q) && (q_q <= $signed(rd_q.t));
	assign last_key = ({1'b0, idx_q} + KEY_CW'(1)) == key_count_q;
	assign diff_c   = 33'(q_q) - 33'($signed(a_q.t));
	assign span_c   = 33'($signed(rd_q.t)) - 33'($signed(a_q.t));

	// one restoring divide step
	assign shl_c  = {rem_q, 1'b0};
	assign sub_ok = shl_c >= {1'b0, span_q};

	// shared multiplier, one component per pass
	always_comb begin
		case (comp_q)
			2'd0:    begin a_comp = a_q.x; b_comp = b_q.x; end
			2'd1:    begin a_comp = a_q.y; b_comp = b_q.y; end
			default: begin a_comp = a_q.z; b_comp = b_q.z; end
		endcase
	end

	assign delta_c = 33'($signed(b_comp)) - 33'($signed(a_comp));
	assign wt_c    = $signed({1'b0, w_q});
	assign prod_c  = delta_c * wt_c;

	// read address for the table, data lands in rd_q next cycle
	always_comb begin
		rd_addr = idx_q;
		unique case (state_q)
			S_IDLE:  rd_addr = '0;
			S_FIRST: rd_addr = KEY_AW'(1);
			S_SCAN:  rd_addr = idx_q + KEY_AW'(1);
			default: rd_addr = idx_q;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q <= key_mem_q[rd_addr];
		if (accept && (req_type == REQ_APPEND) && (key_count_q < KEY_CW'(MAX_KEYS))) begin
			key_mem_q[key_count_q[KEY_AW-1:0]] <= '{t: time_point, x: key_x, y: key_y,
				z: key_z};
		end
	end

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			key_count_q <= '0;
			idx_q       <= '0;
			div_cnt_q   <= '0;
			comp_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_APPEND: begin
								if (key_count_q < KEY_CW'(MAX_KEYS))
									key_count_q <= key_count_q + KEY_CW'(1);
								state_q <= S_DONE;
							end
							REQ_CLEAR: begin
								key_count_q <= '0;
								state_q     <= S_DONE;
							end
							REQ_QUERY: begin
								state_q <= (key_count_q == '0) ? S_DONE : S_FIRST;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_FIRST: begin
					if (first_hit) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= KEY_AW'(1);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (bracket) begin
						div_cnt_q <= '0;
						comp_q    <= '0;
						if (span_c == '0 || diff_c == span_c)
							state_q <= S_MUL;
						else
							state_q <= S_DIV;
					end else if (last_key) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + KEY_AW'(1);
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CW'(1);
					if (div_cnt_q == DIV_CW'(WFRAC - 1))
						state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					comp_q <= comp_q + 2'd1;
					state_q <= (comp_q == 2'd2) ? S_DONE : S_MUL;
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_x_q  <= res_x_q;
			out_y_q  <= res_y_q;
			out_z_q  <= res_z_q;
			out_st_q <= res_st_q;
		end

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					q_q      <= time_point;
					res_x_q  <= '0;
					res_y_q  <= '0;
					res_z_q  <= '0;
					res_st_q <= (req_type == REQ_APPEND && key_count_q >= KEY_CW'(MAX_KEYS))
						? ST_FULL
						: ((req_type == REQ_QUERY && key_count_q == '0) ? ST_EMPTY : ST_OK);
				end
			end
			S_FIRST: begin
				a_q <= rd_q;
				if (first_hit) begin
					res_x_q <= rd_q.x;
					res_y_q <= rd_q.y;
					res_z_q <= rd_q.z;
				end
			end
			S_SCAN: begin
				if (bracket) begin
					b_q    <= rd_q;
					rem_q  <= diff_c[31:0];
					span_q <= span_c[31:0];
					if (span_c == '0)
						w_q <= '0;
					else if (diff_c == span_c)
						w_q <= WW'(1) << WFRAC;
					else
						w_q <= '0;
				end else if (last_key) begin
					res_x_q <= rd_q.x;
					res_y_q <= rd_q.y;
					res_z_q <= rd_q.z;
				end else begin
					a_q <= rd_q;
				end
			end
			S_DIV: begin
				rem_q <= sub_ok ? 32'(shl_c - {1'b0, span_q}) : shl_c[31:0];
				w_q   <= {w_q[WW-2:0], sub_ok};
			end
			S_MUL: begin
				prod_q <= prod_c;
			end
			S_ADD: begin
				// floor(delta * w / 2^16), only the low 32 bits matter
				case (comp_q)
					2'd0:    res_x_q <= a_comp + prod_q[WFRAC+31:WFRAC];
					2'd1:    res_y_q <= a_comp + prod_q[WFRAC+31:WFRAC];
					default: res_z_q <= a_comp + prod_q[WFRAC+31:WFRAC];
				endcase
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;
	assign status    = out_st_q;

	// --------------------------------------------------------------------
	// assertions
	// --------------------------------------------------------------------
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= KEY_CW'(MAX_KEYS))
		else $error("key count above table size");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q != '0) && ({1'b0, idx_q} < key_count_q))
		else $error("scan index outside filled table");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (span_q != '0) && (rem_q < span_q))
		else $error("divider remainder not below span");

	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (w_q <= (WW'(1) << WFRAC)))
		else $error("weight above one");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_CLEAR) |=> (key_count_q == '0))
		else $error("clear did not empty the table");

endmodule
